// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the ray caster RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Types, widths and codes for the grid ray caster.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAP_SIDE  = 64;
    localparam int DEF_MAX_STEPS = 128;

    localparam int CELL_W    = $clog2(MAP_SIDE);
    localparam int ADDR_W    = 2 * CELL_W;
    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;

    localparam int POS_W  = 22;
    localparam int DIR_W  = 18;
    localparam int SW_W   = 13;
    localparam int COL_W  = 12;
    localparam int PERP_W = 24;
    localparam int HIT_W  = 23;
    localparam int CFG_W  = 22;
    localparam int IDX_W  = 3;

    localparam int CAM_W   = 32;
    localparam int RAY_W   = 34;
    localparam int DIST_W  = 41;
    localparam int NUM_W   = 40;
    localparam int DEN_W   = 34;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NUMS_W  = POS_W + 2;

    localparam int ONE = 1 << FRAC_BITS;
    localparam logic [NUM_W-1:0]  DX_NUM   = NUM_W'(1) << (2 * FRAC_BITS);
    localparam logic [PERP_W-1:0] PERP_MAX = '1;
    localparam logic [HIT_W-1:0]  HIT_TOP  = HIT_W'(MAP_SIDE) << FRAC_BITS;

    // s_tdata layout
    localparam int IN_W     = 32;
    localparam int IN_CX_LO = 0;
    localparam int IN_CY_LO = IN_CX_LO + CELL_W;
    localparam int IN_WALL  = IN_CY_LO + CELL_W;
    localparam int IN_COL_LO = IN_WALL + 1;

    // m_tdata layout
    localparam int OUT_USED = COL_W + PERP_W + 2 * HIT_W + 2 * CELL_W + 1 + 2;
    localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
    localparam int OUT_PAD  = OUT_W - OUT_USED;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [IDX_W-1:0] CFG_POS_X    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_POS_Y    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DIR_X    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DIR_Y    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PLANE_X  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PLANE_Y  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SCREEN_W = 3'd6;

    localparam logic [POS_W-1:0] RST_POS_X   = POS_W'(2097152);
    localparam logic [POS_W-1:0] RST_POS_Y   = POS_W'(2097152);
    localparam logic [DIR_W-1:0] RST_DIR_X   = DIR_W'(-65536);
    localparam logic [DIR_W-1:0] RST_DIR_Y   = '0;
    localparam logic [DIR_W-1:0] RST_PLANE_X = '0;
    localparam logic [DIR_W-1:0] RST_PLANE_Y = DIR_W'(43254);
    localparam logic [SW_W-1:0]  RST_SCREEN_W = SW_W'(640);

    localparam logic [1:0] FACE_NORTH = 2'd0;
    localparam logic [1:0] FACE_SOUTH = 2'd1;
    localparam logic [1:0] FACE_EAST  = 2'd2;
    localparam logic [1:0] FACE_WEST  = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_DIV_CAM,
        OP_DIV_DX,
        OP_DIV_DY,
        OP_DIV_SDX,
        OP_DIV_SDY,
        OP_DIV_PERP,
        OP_MUL_RX,
        OP_MUL_RY,
        OP_MUL_HX,
        OP_MUL_HY,
        OP_READ_START,
        OP_STEP,
        OP_ZERO_PERP,
        OP_FINISH,
        OP_NOHIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic map_ready;
        logic div_done;
        logic wall;
        logic leave;
        logic out_busy;
    } st_t;

endpackage

// File: hdl/gcr_div.sv
// ----------------------------------------------------------------------------
// gcr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gcr_pkg::NUM_W-1:0]   num,
    input  logic [gcr_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [gcr_pkg::NUM_W-1:0]   quo
);

    localparam int NW  = gcr_pkg::NUM_W;
    localparam int DW  = gcr_pkg::DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = DW'(trial - {1'b0, den_reg});
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: hdl/gcr_map.sv
// ----------------------------------------------------------------------------
// gcr_map
// Wall bit map with registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
module gcr_map (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [gcr_pkg::ADDR_W-1:0]  wr_addr,
    input  logic                        wr_data,
    input  logic                        rd_en,
    input  logic [gcr_pkg::ADDR_W-1:0]  rd_addr,
    output logic                        rd_data,
    output logic                        ready
);

    localparam int AW = gcr_pkg::ADDR_W;

    logic          mem [gcr_pkg::MAP_DEPTH];
    logic [AW:0]   clr_reg;
    logic          rd_data_reg;
    logic          clearing;

    assign clearing = !clr_reg[AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clearing)
            clr_reg <= clr_reg + (AW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_reg[AW-1:0]] <= 1'b0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing;

endmodule

// File: hdl/gcr_datapath.sv
// ----------------------------------------------------------------------------
// gcr_datapath
// Config registers, ray math, DDA walk registers, map and output register.
// ----------------------------------------------------------------------------
module gcr_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [gcr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gcr_pkg::CFG_W-1:0]   cfg_data,
    input  logic [gcr_pkg::IN_W-1:0]    s_tdata,
    input  logic                        s_tuser,
    input  gcr_pkg::cmd_t               cmd,
    output gcr_pkg::st_t                st,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [gcr_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tuser
);

    localparam int F      = gcr_pkg::FRAC_BITS;
    localparam int CW     = gcr_pkg::CELL_W;
    localparam int RW     = gcr_pkg::RAY_W;
    localparam int HS_W   = gcr_pkg::PROD_W - F + 1;
    localparam int NS_W   = gcr_pkg::NUMS_W;
    localparam logic [CW-1:0] EDGE_HI = CW'(gcr_pkg::MAP_SIDE - 1);

    logic [gcr_pkg::POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic signed [gcr_pkg::DIR_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [gcr_pkg::SW_W-1:0]   screen_w_reg;

    logic [gcr_pkg::COL_W-1:0]  col_reg;
    logic [gcr_pkg::CAM_W-1:0]  cam_reg;
    logic signed [RW-1:0]       rx_reg, ry_reg;
    logic [gcr_pkg::DIST_W-1:0] dx_reg, dy_reg, sdx_reg, sdy_reg;
    logic [CW-1:0]              mx_reg, my_reg;
    logic                       side_reg;
    logic [gcr_pkg::PERP_W-1:0] perp_reg;
    logic [gcr_pkg::HIT_W-1:0]  hx_reg, hy_reg;
    logic signed [gcr_pkg::PROD_W-1:0] prod_reg;
    gcr_pkg::dp_op_t            mul_dst_reg, div_dst_reg;
    logic                       mul_pend_reg;

    logic [gcr_pkg::COL_W-1:0]  o_col_reg;
    logic [gcr_pkg::PERP_W-1:0] o_perp_reg;
    logic [gcr_pkg::HIT_W-1:0]  o_hx_reg, o_hy_reg;
    logic [CW-1:0]              o_cx_reg, o_cy_reg;
    logic                       o_side_reg, o_nohit_reg, o_valid_reg;
    logic [1:0]                 o_face_reg;

    logic                       rx_neg, ry_neg, x_inf, y_inf, take_x, leave;
    logic [RW-1:0]              abs_rx, abs_ry;
    logic [CW-1:0]              nxt_mx, nxt_my, start_mx, start_my;
    logic [F:0]                 frac_x, frac_y;
    logic signed [NS_W-1:0]     num_x, num_y, num_sel, num_abs;
    logic [gcr_pkg::SW_W-1:0]   w_eff;
    logic [gcr_pkg::NUM_W-1:0]  div_num, div_quo;
    logic [gcr_pkg::DEN_W-1:0]  div_den;
    logic                       div_start, div_done, perp_den_zero;
    logic signed [gcr_pkg::MUL_A_W-1:0] mul_a;
    logic signed [gcr_pkg::MUL_B_W-1:0] mul_b;
    logic signed [HS_W-1:0]     hsum_x, hsum_y;
    logic                       map_we, map_re, map_rdata, map_ready;
    logic [gcr_pkg::ADDR_W-1:0] map_waddr, map_raddr;
    logic [1:0]                 face;

    function automatic logic [gcr_pkg::HIT_W-1:0] clamp_hit(input logic signed [HS_W-1:0] v);
        logic [gcr_pkg::HIT_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed(HS_W'(gcr_pkg::HIT_TOP)))
            r = gcr_pkg::HIT_TOP;
        else
            r = v[gcr_pkg::HIT_W-1:0];
        return r;
    endfunction

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= gcr_pkg::RST_POS_X;
            pos_y_reg    <= gcr_pkg::RST_POS_Y;
            dir_x_reg    <= gcr_pkg::RST_DIR_X;
            dir_y_reg    <= gcr_pkg::RST_DIR_Y;
            plane_x_reg  <= gcr_pkg::RST_PLANE_X;
            plane_y_reg  <= gcr_pkg::RST_PLANE_Y;
            screen_w_reg <= gcr_pkg::RST_SCREEN_W;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                gcr_pkg::CFG_POS_X:    pos_x_reg    <= cfg_data[gcr_pkg::POS_W-1:0];
                gcr_pkg::CFG_POS_Y:    pos_y_reg    <= cfg_data[gcr_pkg::POS_W-1:0];
                gcr_pkg::CFG_DIR_X:    dir_x_reg    <= cfg_data[gcr_pkg::DIR_W-1:0];
                gcr_pkg::CFG_DIR_Y:    dir_y_reg    <= cfg_data[gcr_pkg::DIR_W-1:0];
                gcr_pkg::CFG_PLANE_X:  plane_x_reg  <= cfg_data[gcr_pkg::DIR_W-1:0];
                gcr_pkg::CFG_PLANE_Y:  plane_y_reg  <= cfg_data[gcr_pkg::DIR_W-1:0];
                gcr_pkg::CFG_SCREEN_W: screen_w_reg <= cfg_data[gcr_pkg::SW_W-1:0];
                default: ;
            endcase
        end
    end

    // walk decode
    always_comb
    begin
        rx_neg = rx_reg[RW-1];
        ry_neg = ry_reg[RW-1];
        abs_rx = rx_neg ? RW'(-rx_reg) : RW'(rx_reg);
        abs_ry = ry_neg ? RW'(-ry_reg) : RW'(ry_reg);
        x_inf  = (rx_reg == '0);
        y_inf  = (ry_reg == '0);
        take_x = !x_inf && (y_inf || (sdx_reg < sdy_reg));
        if (take_x)
            leave = rx_neg ? (mx_reg == '0) : (mx_reg == EDGE_HI);
        else
            leave = ry_neg ? (my_reg == '0) : (my_reg == EDGE_HI);
        nxt_mx = mx_reg;
        nxt_my = my_reg;
        if (take_x)
            nxt_mx = rx_neg ? mx_reg - CW'(1) : mx_reg + CW'(1);
        else
            nxt_my = ry_neg ? my_reg - CW'(1) : my_reg + CW'(1);
        start_mx = pos_x_reg[gcr_pkg::POS_W-1:F];
        start_my = pos_y_reg[gcr_pkg::POS_W-1:F];
        frac_x = rx_neg ? {1'b0, pos_x_reg[F-1:0]}
                        : (F+1)'(gcr_pkg::ONE) - {1'b0, pos_x_reg[F-1:0]};
        frac_y = ry_neg ? {1'b0, pos_y_reg[F-1:0]}
                        : (F+1)'(gcr_pkg::ONE) - {1'b0, pos_y_reg[F-1:0]};
        num_x = $signed(NS_W'({mx_reg, {F{1'b0}}})) - $signed(NS_W'(pos_x_reg))
              + (rx_neg ? $signed(NS_W'(gcr_pkg::ONE)) : $signed(NS_W'(0)));
        num_y = $signed(NS_W'({my_reg, {F{1'b0}}})) - $signed(NS_W'(pos_y_reg))
              + (ry_neg ? $signed(NS_W'(gcr_pkg::ONE)) : $signed(NS_W'(0)));
        num_sel = side_reg ? num_y : num_x;
        num_abs = num_sel[NS_W-1] ? -num_sel : num_sel;
        perp_den_zero = side_reg ? y_inf : x_inf;
        w_eff = (screen_w_reg == '0) ? gcr_pkg::SW_W'(1) : screen_w_reg;
    end

    // divider operands
    always_comb
    begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            gcr_pkg::OP_DIV_CAM:
            begin
                div_num = gcr_pkg::NUM_W'({col_reg, {(F+1){1'b0}}});
                div_den = gcr_pkg::DEN_W'(w_eff);
            end
            gcr_pkg::OP_DIV_DX:
            begin
                div_num = gcr_pkg::DX_NUM;
                div_den = abs_rx;
            end
            gcr_pkg::OP_DIV_DY:
            begin
                div_num = gcr_pkg::DX_NUM;
                div_den = abs_ry;
            end
            gcr_pkg::OP_DIV_SDX:
            begin
                div_num = gcr_pkg::NUM_W'({frac_x, {F{1'b0}}});
                div_den = abs_rx;
            end
            gcr_pkg::OP_DIV_SDY:
            begin
                div_num = gcr_pkg::NUM_W'({frac_y, {F{1'b0}}});
                div_den = abs_ry;
            end
            gcr_pkg::OP_DIV_PERP:
            begin
                div_num = gcr_pkg::NUM_W'({num_abs[NS_W-2:0], {F{1'b0}}});
                div_den = side_reg ? abs_ry : abs_rx;
            end
            default: div_start = 1'b0;
        endcase
    end

    gcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // multiplier operands
    always_comb
    begin
        mul_a = gcr_pkg::MUL_A_W'(plane_x_reg);
        mul_b = $signed(cam_reg);
        case (cmd.op)
            gcr_pkg::OP_MUL_RY: mul_a = gcr_pkg::MUL_A_W'(plane_y_reg);
            gcr_pkg::OP_MUL_HX:
            begin
                mul_a = gcr_pkg::MUL_A_W'(rx_reg);
                mul_b = $signed(gcr_pkg::MUL_B_W'(perp_reg));
            end
            gcr_pkg::OP_MUL_HY:
            begin
                mul_a = gcr_pkg::MUL_A_W'(ry_reg);
                mul_b = $signed(gcr_pkg::MUL_B_W'(perp_reg));
            end
            default: ;
        endcase
        hsum_x = HS_W'($signed(prod_reg[gcr_pkg::PROD_W-1:F])) + $signed(HS_W'(pos_x_reg));
        hsum_y = HS_W'($signed(prod_reg[gcr_pkg::PROD_W-1:F])) + $signed(HS_W'(pos_y_reg));
        if (side_reg)
            face = (!ry_neg && !y_inf) ? gcr_pkg::FACE_SOUTH : gcr_pkg::FACE_NORTH;
        else
            face = (!rx_neg && !x_inf) ? gcr_pkg::FACE_EAST : gcr_pkg::FACE_WEST;
    end

    // map ports
    always_comb
    begin
        map_we    = (cmd.op == gcr_pkg::OP_ACCEPT) && (s_tuser == gcr_pkg::OP_WRITE);
        map_waddr = {s_tdata[gcr_pkg::IN_CY_LO +: CW], s_tdata[gcr_pkg::IN_CX_LO +: CW]};
        map_re    = (cmd.op == gcr_pkg::OP_READ_START) || (cmd.op == gcr_pkg::OP_STEP);
        map_raddr = (cmd.op == gcr_pkg::OP_STEP) ? {nxt_my, nxt_mx} : {start_my, start_mx};
    end

    gcr_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (s_tdata[gcr_pkg::IN_WALL]),
        .rd_en   (map_re),
        .rd_addr (map_raddr),
        .rd_data (map_rdata),
        .ready   (map_ready)
    );

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            mul_pend_reg <= (cmd.op == gcr_pkg::OP_MUL_RX) || (cmd.op == gcr_pkg::OP_MUL_RY)
                         || (cmd.op == gcr_pkg::OP_MUL_HX) || (cmd.op == gcr_pkg::OP_MUL_HY);
            if ((cmd.op == gcr_pkg::OP_FINISH) || (cmd.op == gcr_pkg::OP_NOHIT))
                o_valid_reg <= 1'b1;
            else if (m_tready)
                o_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (div_start)
            div_dst_reg <= cmd.op;
        mul_dst_reg <= cmd.op;
        prod_reg    <= mul_a * mul_b;

        if (div_done)
        begin
            case (div_dst_reg)
                gcr_pkg::OP_DIV_CAM:
                    cam_reg <= gcr_pkg::CAM_W'(div_quo) - gcr_pkg::CAM_W'(gcr_pkg::ONE);
                gcr_pkg::OP_DIV_DX:  dx_reg  <= gcr_pkg::DIST_W'(div_quo);
                gcr_pkg::OP_DIV_DY:  dy_reg  <= gcr_pkg::DIST_W'(div_quo);
                gcr_pkg::OP_DIV_SDX: sdx_reg <= gcr_pkg::DIST_W'(div_quo);
                gcr_pkg::OP_DIV_SDY: sdy_reg <= gcr_pkg::DIST_W'(div_quo);
                gcr_pkg::OP_DIV_PERP:
                begin
                    if (perp_den_zero || (|div_quo[gcr_pkg::NUM_W-1:gcr_pkg::PERP_W]))
                        perp_reg <= gcr_pkg::PERP_MAX;
                    else
                        perp_reg <= div_quo[gcr_pkg::PERP_W-1:0];
                end
                default: ;
            endcase
        end

        if (mul_pend_reg)
        begin
            case (mul_dst_reg)
                gcr_pkg::OP_MUL_RX:
                    rx_reg <= RW'($signed(prod_reg[RW+F-1:F])) + RW'(dir_x_reg);
                gcr_pkg::OP_MUL_RY:
                    ry_reg <= RW'($signed(prod_reg[RW+F-1:F])) + RW'(dir_y_reg);
                gcr_pkg::OP_MUL_HX: hx_reg <= clamp_hit(hsum_x);
                gcr_pkg::OP_MUL_HY: hy_reg <= clamp_hit(hsum_y);
                default: ;
            endcase
        end

        case (cmd.op)
            gcr_pkg::OP_ACCEPT:
                col_reg <= s_tdata[gcr_pkg::IN_COL_LO +: gcr_pkg::COL_W];
            gcr_pkg::OP_READ_START:
            begin
                mx_reg   <= start_mx;
                my_reg   <= start_my;
                side_reg <= 1'b0;
            end
            gcr_pkg::OP_STEP:
            begin
                mx_reg <= nxt_mx;
                my_reg <= nxt_my;
                if (take_x)
                begin
                    sdx_reg  <= sdx_reg + dx_reg;
                    side_reg <= 1'b0;
                end
                else
                begin
                    if (!y_inf)
                        sdy_reg <= sdy_reg + dy_reg;
                    side_reg <= 1'b1;
                end
            end
            gcr_pkg::OP_ZERO_PERP:
                perp_reg <= '0;
            gcr_pkg::OP_FINISH:
            begin
                o_col_reg   <= col_reg;
                o_perp_reg  <= perp_reg;
                o_hx_reg    <= hx_reg;
                o_hy_reg    <= hy_reg;
                o_cx_reg    <= mx_reg;
                o_cy_reg    <= my_reg;
                o_side_reg  <= side_reg;
                o_face_reg  <= face;
                o_nohit_reg <= 1'b0;
            end
            gcr_pkg::OP_NOHIT:
            begin
                o_col_reg   <= col_reg;
                o_perp_reg  <= '0;
                o_hx_reg    <= '0;
                o_hy_reg    <= '0;
                o_cx_reg    <= '0;
                o_cy_reg    <= '0;
                o_side_reg  <= 1'b0;
                o_face_reg  <= gcr_pkg::FACE_NORTH;
                o_nohit_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st.map_ready = map_ready;
        st.div_done  = div_done;
        st.wall      = map_rdata;
        st.leave     = leave;
        st.out_busy  = o_valid_reg && !m_tready;
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_nohit_reg;
    assign m_tdata  = {{gcr_pkg::OUT_PAD{1'b0}}, o_face_reg, o_side_reg, o_cy_reg, o_cx_reg,
                       o_hy_reg, o_hx_reg, o_perp_reg, o_col_reg};

endmodule

// File: hdl/gcr_ctrl.sv
// ----------------------------------------------------------------------------
// gcr_ctrl
// Sequencer for one request: ray setup, divisions, DDA walk, result load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcr_ctrl #(
    parameter int MAX_STEPS = gcr_pkg::DEF_MAX_STEPS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tuser,
    output logic          s_tready,
    input  gcr_pkg::st_t  st,
    output gcr_pkg::cmd_t cmd
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DIV_WAIT,
        S_MUL_RX,
        S_MUL_RY,
        S_MUL_R_WAIT,
        S_START,
        S_CHECK_START,
        S_STEP,
        S_CHECK,
        S_ZERO,
        S_MUL_HX,
        S_MUL_HY,
        S_MUL_H_WAIT,
        S_FINISH,
        S_NOHIT
    } state_t;

    state_t          state_reg, state_next;
    gcr_pkg::dp_op_t div_op_reg, div_op_next;
    logic [STEP_W-1:0] steps_reg, steps_next;

    always_comb
    begin
        state_next  = state_reg;
        div_op_next = div_op_reg;
        steps_next  = steps_reg;
        cmd.op      = gcr_pkg::OP_NONE;
        s_tready    = (state_reg == S_IDLE) && st.map_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.op = gcr_pkg::OP_ACCEPT;
                    if (s_tuser == gcr_pkg::OP_CAST)
                    begin
                        div_op_next = gcr_pkg::OP_DIV_CAM;
                        state_next  = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.op     = div_op_reg;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    state_next = S_DIV;
                    case (div_op_reg)
                        gcr_pkg::OP_DIV_CAM:  state_next = S_MUL_RX;
                        gcr_pkg::OP_DIV_DX:   div_op_next = gcr_pkg::OP_DIV_DY;
                        gcr_pkg::OP_DIV_DY:   div_op_next = gcr_pkg::OP_DIV_SDX;
                        gcr_pkg::OP_DIV_SDX:  div_op_next = gcr_pkg::OP_DIV_SDY;
                        gcr_pkg::OP_DIV_SDY:  state_next = S_CHECK_START;
                        default:              state_next = S_MUL_HX;
                    endcase
                end
            end
            S_MUL_RX:
            begin
                cmd.op     = gcr_pkg::OP_MUL_RX;
                state_next = S_MUL_RY;
            end
            S_MUL_RY:
            begin
                cmd.op     = gcr_pkg::OP_MUL_RY;
                state_next = S_MUL_R_WAIT;
            end
            S_MUL_R_WAIT:
                state_next = S_START;
            S_START:
            begin
                cmd.op      = gcr_pkg::OP_READ_START;
                steps_next  = '0;
                div_op_next = gcr_pkg::OP_DIV_DX;
                state_next  = S_DIV;
            end
            S_CHECK_START:
                state_next = st.wall ? S_ZERO : S_STEP;
            S_STEP:
            begin
                if ((steps_reg >= STEP_W'(MAX_STEPS)) || st.leave)
                    state_next = S_NOHIT;
                else
                begin
                    cmd.op     = gcr_pkg::OP_STEP;
                    steps_next = steps_reg + STEP_W'(1);
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.wall)
                begin
                    div_op_next = gcr_pkg::OP_DIV_PERP;
                    state_next  = S_DIV;
                end
                else
                    state_next = S_STEP;
            end
            S_ZERO:
            begin
                cmd.op     = gcr_pkg::OP_ZERO_PERP;
                state_next = S_MUL_HX;
            end
            S_MUL_HX:
            begin
                cmd.op     = gcr_pkg::OP_MUL_HX;
                state_next = S_MUL_HY;
            end
            S_MUL_HY:
            begin
                cmd.op     = gcr_pkg::OP_MUL_HY;
                state_next = S_MUL_H_WAIT;
            end
            S_MUL_H_WAIT:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    cmd.op     = gcr_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            S_NOHIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.op     = gcr_pkg::OP_NOHIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            div_op_reg <= gcr_pkg::OP_DIV_CAM;
            steps_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            div_op_reg <= div_op_next;
            steps_reg  <= steps_next;
        end
    end

    `ASSERT_IMP(a_step_limit, clk, rst_n, cmd.op == gcr_pkg::OP_STEP, steps_reg < STEP_W'(MAX_STEPS))
    `ASSERT_IMP(a_out_free, clk, rst_n, cmd.op == gcr_pkg::OP_FINISH || cmd.op == gcr_pkg::OP_NOHIT, !st.out_busy)
    `ASSERT_NXT(a_cast_busy, clk, rst_n, s_tvalid && s_tready && s_tuser == gcr_pkg::OP_CAST, !s_tready)

endmodule

// File: hdl/grid_ray_caster_dda.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_dda
// DDA ray caster over a 64x64 wall bit map, one screen column per request.
//
//   channel  dir  handshake           payload
//   cfg      in   cfg_wr_en           cfg_index, cfg_data
//   s        in   s_tvalid/s_tready   s_tdata, s_tuser (0 map write, 1 cast)
//   m        out  m_tvalid/m_tready   m_tdata, m_tuser (no hit)
//
// A cast that hits runs six divisions in the shared divider, one that leaves
// the map or starts inside a wall runs five.
// After reset the map clears with s_tready low.
// One result register decouples the output; a cast waits at its end only
// while the previous result is still held.
// ----------------------------------------------------------------------------
module grid_ray_caster_dda #(
    parameter int MAX_STEPS = gcr_pkg::DEF_MAX_STEPS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [gcr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gcr_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // cell_x, cell_y, cell_is_wall, column
    input  logic [gcr_pkg::IN_W-1:0]    s_tdata,
    // operation
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // column_out, perp_distance, hit_x, hit_y, hit_cell_x, hit_cell_y,
    // hit_side, wall_face
    output logic [gcr_pkg::OUT_W-1:0]   m_tdata,
    // no_hit
    output logic                        m_tuser
);

    gcr_pkg::cmd_t cmd;
    gcr_pkg::st_t  st;

    gcr_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    gcr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_ray_caster_dda. Map writes and ray casts are
// streamed in with random gaps while the result side stalls at random. A
// scoreboard keeps its own map and view settings, predicts each cast in
// fixed point and checks every result field in order.
// ----------------------------------------------------------------------------
class ray_scoreboard;
    localparam longint UNIT = 65536;
    localparam longint unsigned HUGE_DIST = 64'd1 << 62;
    localparam longint unsigned PERP_SAT = (64'd1 << 24) - 1;

    bit wall_bits [4096];
    longint pos_x, pos_y, dir_x, dir_y, pln_x, pln_y;
    longint unsigned scr_w;
    logic [104:0] pending_rays [$];
    int errors, writes, casts, hits, misses;

    function new();
        pos_x = longint'(gcr_pkg::RST_POS_X);
        pos_y = longint'(gcr_pkg::RST_POS_Y);
        dir_x = longint'($signed(gcr_pkg::RST_DIR_X));
        dir_y = longint'($signed(gcr_pkg::RST_DIR_Y));
        pln_x = longint'($signed(gcr_pkg::RST_PLANE_X));
        pln_y = longint'($signed(gcr_pkg::RST_PLANE_Y));
        scr_w = 64'(gcr_pkg::RST_SCREEN_W);
    endfunction

    function void set_cfg(logic [2:0] idx, logic [21:0] v);
        case (idx)
            gcr_pkg::CFG_POS_X:    pos_x = longint'(v);
            gcr_pkg::CFG_POS_Y:    pos_y = longint'(v);
            gcr_pkg::CFG_DIR_X:    dir_x = longint'($signed(v[17:0]));
            gcr_pkg::CFG_DIR_Y:    dir_y = longint'($signed(v[17:0]));
            gcr_pkg::CFG_PLANE_X:  pln_x = longint'($signed(v[17:0]));
            gcr_pkg::CFG_PLANE_Y:  pln_y = longint'($signed(v[17:0]));
            gcr_pkg::CFG_SCREEN_W: scr_w = 64'(v[12:0]);
            default: ;
        endcase
    endfunction

    function longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        return (a + b > HUGE_DIST) ? HUGE_DIST : a + b;
    endfunction

    function longint clamp_hit(longint v);
        return v < 0 ? 0 : (v > 64 * UNIT ? 64 * UNIT : v);
    endfunction

    function bit on_map(longint c);
        return c >= 0 && c < 64;
    endfunction

    // bit 104 = no hit, bits 96:0 = packed result fields
    function logic [104:0] cast_ray(logic [11:0] col);
        longint cam, rx, ry, mx, my, sx, sy, num, rd, hx, hy;
        longint unsigned w, dx, dy, sdx, sdy, perp, frac;
        int side, steps;
        logic [104:0] e;
        e = '0;
        e[11:0] = col;
        side = 0;
        steps = 0;
        w = scr_w == 0 ? 1 : scr_w;
        cam = longint'(((64'(col) * 2) << 16) / w) - UNIT;
        rx = dir_x + ((pln_x * cam) >>> 16);
        ry = dir_y + ((pln_y * cam) >>> 16);
        mx = pos_x >>> 16;
        my = pos_y >>> 16;
        if (!on_map(mx) || !on_map(my))
        begin
            e[104] = 1'b1;
            return e;
        end
        dx = rx != 0 ? (64'd1 << 32) / mag(rx) : HUGE_DIST;
        dy = ry != 0 ? (64'd1 << 32) / mag(ry) : HUGE_DIST;
        sx = rx < 0 ? -1 : 1;
        sy = ry < 0 ? -1 : 1;
        frac = rx < 0 ? pos_x - mx * UNIT : (mx + 1) * UNIT - pos_x;
        sdx = rx != 0 ? (frac << 16) / mag(rx) : HUGE_DIST;
        frac = ry < 0 ? pos_y - my * UNIT : (my + 1) * UNIT - pos_y;
        sdy = ry != 0 ? (frac << 16) / mag(ry) : HUGE_DIST;
        if (wall_bits[my * 64 + mx])
            perp = 0;
        else
        begin
            while (1)
            begin
                if (steps >= 128)
                begin
                    e[104] = 1'b1;
                    return e;
                end
                steps++;
                if (sdx < sdy)
                begin
                    sdx = sat_sum(sdx, dx);
                    mx += sx;
                    side = 0;
                end
                else
                begin
                    sdy = sat_sum(sdy, dy);
                    my += sy;
                    side = 1;
                end
                if (!on_map(mx) || !on_map(my))
                begin
                    e[104] = 1'b1;
                    return e;
                end
                if (wall_bits[my * 64 + mx])
                    break;
            end
            if (side == 0)
            begin
                num = mx * UNIT - pos_x + (sx < 0 ? UNIT : 0);
                rd = rx;
            end
            else
            begin
                num = my * UNIT - pos_y + (sy < 0 ? UNIT : 0);
                rd = ry;
            end
            perp = rd != 0 ? (mag(num) << 16) / mag(rd) : PERP_SAT;
            if (perp > PERP_SAT)
                perp = PERP_SAT;
        end
        hx = clamp_hit(pos_x + ((rx * longint'(perp)) >>> 16));
        hy = clamp_hit(pos_y + ((ry * longint'(perp)) >>> 16));
        e[35:12] = 24'(perp);
        e[58:36] = 23'(hx);
        e[81:59] = 23'(hy);
        e[87:82] = 6'(mx);
        e[93:88] = 6'(my);
        e[94] = 1'(side);
        if (side != 0)
            e[96:95] = ry > 0 ? gcr_pkg::FACE_SOUTH : gcr_pkg::FACE_NORTH;
        else
            e[96:95] = rx > 0 ? gcr_pkg::FACE_EAST : gcr_pkg::FACE_WEST;
        return e;
    endfunction

    function void note_request(logic op, logic [31:0] d);
        if (op == gcr_pkg::OP_WRITE)
        begin
            wall_bits[{d[11:6], d[5:0]}] = d[12];
            writes++;
        end
        else
        begin
            pending_rays.push_back(cast_ray(d[24:13]));
            casts++;
        end
    endfunction

    task report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    task cmp(string name, longint unsigned got, longint unsigned want);
        if (got != want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(logic [103:0] d, logic nh);
        logic [104:0] e;
        if (pending_rays.size() == 0)
        begin
            report("result with no cast outstanding");
            return;
        end
        e = pending_rays.pop_front();
        if (e[104]) misses++; else hits++;
        cmp("column_out", 64'(d[11:0]), 64'(e[11:0]));
        cmp("perp_distance", 64'(d[35:12]), 64'(e[35:12]));
        cmp("hit_x", 64'(d[58:36]), 64'(e[58:36]));
        cmp("hit_y", 64'(d[81:59]), 64'(e[81:59]));
        cmp("hit_cell_x", 64'(d[87:82]), 64'(e[87:82]));
        cmp("hit_cell_y", 64'(d[93:88]), 64'(e[93:88]));
        cmp("hit_side", 64'(d[94]), 64'(e[94]));
        cmp("wall_face", 64'(d[96:95]), 64'(e[96:95]));
        cmp("no_hit", 64'(nh), 64'(e[104]));
    endtask
endclass

module tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int N_ITEMS = 1700;
    localparam logic [gcr_pkg::IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [gcr_pkg::IDX_W-1:0] cfg_index = '0;
    logic [gcr_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [gcr_pkg::IN_W-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [gcr_pkg::OUT_W-1:0] m_tdata;
    logic m_tuser;

    ray_scoreboard sb = new();
    int accepted = 0;
    int quiet_cycles = 0;
    int out_stall = 0;
    int items = 0;
    bit calm = 0;

    grid_ray_caster_dda dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sb.note_request(s_tuser, s_tdata);
            accepted++;
        end
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no traffic for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            m_tready = 0;
            out_stall--;
        end
        else
        begin
            m_tready = 1;
            if (!calm && $urandom_range(0, 7) == 0)
                out_stall = $urandom_range(1, 6);
        end
    end

    task send(logic op, logic [5:0] cx, logic [5:0] cy, logic w, logic [11:0] col);
        int prev;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid = 1;
        s_tuser = op;
        s_tdata = {7'd0, col, w, cy, cx};
        prev = accepted;
        do @(negedge clk); while (accepted == prev);
        items++;
    endtask

    task cast(logic [11:0] col);
        send(gcr_pkg::OP_CAST, 6'($urandom), 6'($urandom), 1'($urandom), col);
    endtask

    task put_cell(logic [5:0] cx, logic [5:0] cy, logic w);
        send(gcr_pkg::OP_WRITE, cx, cy, w, 12'($urandom));
    endtask

    task cfg_write(logic [gcr_pkg::IDX_W-1:0] idx, logic [gcr_pkg::CFG_W-1:0] v);
        cfg_wr_en = 1;
        cfg_index = idx;
        cfg_data = v;
        sb.set_cfg(idx, v);
        @(negedge clk);
        cfg_wr_en = 0;
    endtask

    task drain();
        s_tvalid = 0;
        while (sb.pending_rays.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function logic [gcr_pkg::CFG_W-1:0] pick_dir();
        case ($urandom_range(0, 5))
            0: return {4'($urandom_range(0, 15)), 18'h20000};
            1: return 22'h1FFFF;
            2: return {4'($urandom_range(0, 15)), 18'(-65536)};
            3: return 22'd65536;
            default: return 22'($urandom);
        endcase
    endfunction

    task new_view();
        case ($urandom_range(0, 3))
            0: cfg_write(gcr_pkg::CFG_POS_X, 22'd0);
            1: cfg_write(gcr_pkg::CFG_POS_X, 22'h3FFFFF);
            default: cfg_write(gcr_pkg::CFG_POS_X, 22'($urandom));
        endcase
        case ($urandom_range(0, 3))
            0: cfg_write(gcr_pkg::CFG_POS_Y, 22'd0);
            1: cfg_write(gcr_pkg::CFG_POS_Y, 22'h3FFFFF);
            default: cfg_write(gcr_pkg::CFG_POS_Y, 22'($urandom));
        endcase
        cfg_write(gcr_pkg::CFG_DIR_X, pick_dir());
        cfg_write(gcr_pkg::CFG_DIR_Y, pick_dir());
        cfg_write(gcr_pkg::CFG_PLANE_X, pick_dir());
        cfg_write(gcr_pkg::CFG_PLANE_Y, pick_dir());
        case ($urandom_range(0, 7))
            0: cfg_write(gcr_pkg::CFG_SCREEN_W, 22'd0);
            1: cfg_write(gcr_pkg::CFG_SCREEN_W, 22'd1);
            2: cfg_write(gcr_pkg::CFG_SCREEN_W, 22'd4096);
            3: cfg_write(gcr_pkg::CFG_SCREEN_W, {9'($urandom_range(0, 511)), 13'h1FFF});
            default: cfg_write(gcr_pkg::CFG_SCREEN_W, 22'($urandom_range(2, 800)));
        endcase
        cfg_write(CFG_UNUSED, 22'($urandom));
    endtask

    initial
    begin
        int wmax;
        repeat (7) @(negedge clk);
        rst_n = 1;

        // directed: reset view, empty map, corners, start inside a wall
        cast(12'd0);
        cast(12'd320);
        cast(12'd4095);
        put_cell(6'd0, 6'd0, 1'b1);
        put_cell(6'd63, 6'd63, 1'b1);
        put_cell(6'd0, 6'd32, 1'b1);
        put_cell(6'd32, 6'd32, 1'b1);
        cast(12'd639);
        cast(12'd320);
        put_cell(6'd32, 6'd32, 1'b0);
        cast(12'd320);
        cast(12'd100);
        drain();
        cfg_write(gcr_pkg::CFG_SCREEN_W, 22'd0);
        cfg_write(gcr_pkg::CFG_POS_X, 22'h3FFFFF);
        cfg_write(gcr_pkg::CFG_POS_Y, 22'd0);
        cfg_write(gcr_pkg::CFG_DIR_X, 22'h1FFFF);
        cfg_write(gcr_pkg::CFG_DIR_Y, 22'h20000);
        cfg_write(gcr_pkg::CFG_PLANE_X, 22'd0);
        cfg_write(gcr_pkg::CFG_PLANE_Y, 22'd0);
        cfg_write(CFG_UNUSED, 22'h155555);
        cast(12'd0);
        cast(12'd4095);
        put_cell(6'd0, 6'd0, 1'b0);
        put_cell(6'd63, 6'd63, 1'b0);
        put_cell(6'd0, 6'd32, 1'b0);
        drain();

        // outer ring of walls so most rays end on a hit
        for (int i = 0; i < 64; i++)
        begin
            put_cell(6'(i), 6'd0, 1'b1);
            put_cell(6'(i), 6'd63, 1'b1);
            if (i > 0 && i < 63)
            begin
                put_cell(6'd0, 6'(i), 1'b1);
                put_cell(6'd63, 6'(i), 1'b1);
            end
        end

        while (items < N_ITEMS)
        begin
            drain();
            new_view();
            wmax = (sb.scr_w == 0) ? 1 : (sb.scr_w > 4096 ? 4096 : int'(sb.scr_w));
            repeat (150)
            begin
                calm = items > N_ITEMS - 200;
                if ($urandom_range(0, 99) < 35)
                    put_cell(6'($urandom), 6'($urandom), $urandom_range(0, 9) < 3);
                else if ($urandom_range(0, 4) == 0)
                    cast(12'($urandom));
                else
                    cast(12'($urandom_range(0, wmax - 1)));
            end
        end

        s_tvalid = 0;
        while (sb.pending_rays.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        $display("Covered %0d map writes and %0d casts (%0d hits, %0d no-hit).",
                 sb.writes, sb.casts, sb.hits, sb.misses);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
